// ----- rtl/core/gdad_pkg.sv -----
// shared types, constants and calendar helpers for the date add and difference block
package gdad_pkg;

   // field widths
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 20;
   localparam int DIFF_W  = 22;
   localparam int STAT_W  = 2;
   // day number from 1/1/0, covers the last year plus the largest day count
   localparam int DNUM_W  = 23;

   // last year a valid date may carry
   localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

   // largest reported difference
   localparam logic [DNUM_W-1:0] DIFF_MAX = {1'b0, {DIFF_W{1'b1}}};

   // status codes
   localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_BAD_FIRST  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BAD_SECOND = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_OVERFLOW   = 2'd3;

   // operation modes
   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_DIFF = 1'b1;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_YEAR1,
      ST_WALK_MONTH1,
      ST_CHECK1,
      ST_SAVE,
      ST_WALK_YEAR2,
      ST_WALK_MONTH2,
      ST_CHECK2,
      ST_DIFF,
      ST_SPLIT_YEAR,
      ST_SPLIT_MONTH,
      ST_FINISH
   } state_type;

   // which result the datapath records
   typedef enum logic [2:0] {
      RES_NONE,
      RES_BAD_FIRST,
      RES_BAD_SECOND,
      RES_OVERFLOW,
      RES_DATE,
      RES_DIFF
   } res_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        load;
      logic        clear;
      logic        sel_second;
      logic        year_add;
      logic        month_add;
      logic        offset;
      logic        save_first;
      logic        year_sub;
      logic        month_sub;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic mode;
      logic year_hit;
      logic month_hit;
      logic date_ok;
      logic year_more;
      logic year_last;
      logic month_more;
   } stat_type;

   // length of a month, zero for a month code outside 1 to 12
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/core/gdad_datapath.sv -----
// datapath: captured item, year and month walker, day number accumulator, results
module gdad_datapath
   import gdad_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [71:0]          req_tdata,
   input  logic                 req_tuser,
   output logic [47:0]          rsp_tdata
);

   // captured item
   logic               mode_ff;
   logic [DAY_W-1:0]   day1_ff, day2_ff;
   logic [MONTH_W-1:0] month1_ff, month2_ff;
   logic [YEAR_W-1:0]  year1_ff, year2_ff;
   logic [COUNT_W-1:0] count_ff;

   // walker
   logic [YEAR_W-1:0]  yr_ff, yr_in;
   logic [6:0]         c100_ff, c100_in;
   logic [1:0]         cent_ff, cent_in;
   logic [MONTH_W-1:0] mon_ff, mon_in;
   logic [DNUM_W-1:0]  acc_ff, acc_in;
   logic [DNUM_W-1:0]  first_ff;

   // pending result and output register
   logic [DAY_W-1:0]   res_day_ff, res_day_in;
   logic [MONTH_W-1:0] res_month_ff, res_month_in;
   logic [YEAR_W-1:0]  res_year_ff, res_year_in;
   logic [DIFF_W-1:0]  res_diff_ff, res_diff_in;
   logic [STAT_W-1:0]  res_stat_ff, res_stat_in;
   logic [47:0]        out_ff;

   logic               leap;
   logic [8:0]         year_len;
   logic [DAY_W-1:0]   mon_len;
   logic [DAY_W-1:0]   tgt_day;
   logic [MONTH_W-1:0] tgt_month;
   logic [YEAR_W-1:0]  tgt_year;
   logic [DAY_W-1:0]   tgt_len;
   logic [DNUM_W-1:0]  add_count;
   logic [DNUM_W-1:0]  abs_diff;
   logic [YEAR_W-1:0]  yr_next;
   logic [6:0]         c100_next;
   logic [1:0]         cent_next;

   // leap rule from the walker's residues
   assign leap     = (yr_ff[1:0] == 2'd0) && ((c100_ff != 7'd0) || (cent_ff == 2'd0));
   assign year_len = leap ? 9'd366 : 9'd365;
   assign mon_len  = month_length(mon_ff, leap);

   // date under test
   assign tgt_day   = cmd.sel_second ? day2_ff : day1_ff;
   assign tgt_month = cmd.sel_second ? month2_ff : month1_ff;
   assign tgt_year  = cmd.sel_second ? year2_ff : year1_ff;
   assign tgt_len   = month_length(tgt_month, leap);
   assign add_count = (mode_ff == MODE_ADD && !cmd.sel_second)
                    ? {{(DNUM_W-COUNT_W){1'b0}}, count_ff} : '0;

   // next year and its residues
   assign yr_next   = yr_ff + 14'd1;
   assign c100_next = (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
   assign cent_next = (c100_ff == 7'd99) ? cent_ff + 2'd1 : cent_ff;

   // status to controller
   assign stat.mode       = mode_ff;
   assign stat.year_hit   = (yr_ff == tgt_year);
   assign stat.month_hit  = (mon_ff >= tgt_month) || (mon_ff == 4'd12);
   assign stat.date_ok    = (tgt_year <= MAX_YEAR) && (tgt_day != 5'd0) && (tgt_day <= tgt_len);
   assign stat.year_more  = (acc_ff >= {{(DNUM_W-9){1'b0}}, year_len});
   assign stat.year_last  = (yr_ff == MAX_YEAR);
   assign stat.month_more = (mon_ff < 4'd12) &&
                            (acc_ff >= {{(DNUM_W-DAY_W){1'b0}}, mon_len});

   assign abs_diff = (first_ff > acc_ff) ? first_ff - acc_ff : acc_ff - first_ff;

   // walker next values
   always_comb begin
      yr_in   = yr_ff;
      c100_in = c100_ff;
      cent_in = cent_ff;
      mon_in  = mon_ff;
      acc_in  = acc_ff;
      if (cmd.clear) begin
         yr_in   = '0;
         c100_in = '0;
         cent_in = '0;
         mon_in  = 4'd1;
         acc_in  = '0;
      end else if (cmd.offset) begin
         yr_in   = '0;
         c100_in = '0;
         cent_in = '0;
         mon_in  = 4'd1;
         acc_in  = acc_ff + {{(DNUM_W-DAY_W){1'b0}}, tgt_day} - 23'd1 + add_count;
      end else if (cmd.year_add || cmd.year_sub) begin
         yr_in   = yr_next;
         c100_in = c100_next;
         cent_in = cent_next;
         acc_in  = cmd.year_add ? acc_ff + {{(DNUM_W-9){1'b0}}, year_len}
                                : acc_ff - {{(DNUM_W-9){1'b0}}, year_len};
      end else if (cmd.month_add || cmd.month_sub) begin
         mon_in = mon_ff + 4'd1;
         acc_in = cmd.month_add ? acc_ff + {{(DNUM_W-DAY_W){1'b0}}, mon_len}
                                : acc_ff - {{(DNUM_W-DAY_W){1'b0}}, mon_len};
      end
   end

   // result selection
   always_comb begin
      res_day_in   = res_day_ff;
      res_month_in = res_month_ff;
      res_year_in  = res_year_ff;
      res_diff_in  = res_diff_ff;
      res_stat_in  = res_stat_ff;
      case (cmd.res_sel)
         RES_NONE: begin
         end
         RES_BAD_FIRST, RES_BAD_SECOND, RES_OVERFLOW: begin
            res_day_in   = '0;
            res_month_in = '0;
            res_year_in  = '0;
            res_diff_in  = '0;
            res_stat_in  = (cmd.res_sel == RES_BAD_FIRST)  ? STATUS_BAD_FIRST :
                           (cmd.res_sel == RES_BAD_SECOND) ? STATUS_BAD_SECOND :
                                                             STATUS_OVERFLOW;
         end
         RES_DATE: begin
            res_day_in   = acc_ff[DAY_W-1:0] + 5'd1;
            res_month_in = mon_ff;
            res_year_in  = yr_ff;
            res_diff_in  = '0;
            res_stat_in  = STATUS_OK;
         end
         RES_DIFF: begin
            res_day_in   = '0;
            res_month_in = '0;
            res_year_in  = '0;
            res_diff_in  = (abs_diff > DIFF_MAX) ? DIFF_MAX[DIFF_W-1:0]
                                                 : abs_diff[DIFF_W-1:0];
            res_stat_in  = STATUS_OK;
         end
         default: begin
         end
      endcase
   end

   // item capture on input transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_tuser;
         day1_ff   <= req_tdata[4:0];
         month1_ff <= req_tdata[8:5];
         year1_ff  <= req_tdata[22:9];
         day2_ff   <= req_tdata[27:23];
         month2_ff <= req_tdata[31:28];
         year2_ff  <= req_tdata[45:32];
         count_ff  <= req_tdata[65:46];
      end
   end

   // walker and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         yr_ff   <= '0;
         c100_ff <= '0;
         cent_ff <= '0;
         mon_ff  <= 4'd1;
      end else begin
         yr_ff   <= yr_in;
         c100_ff <= c100_in;
         cent_ff <= cent_in;
         mon_ff  <= mon_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      res_day_ff   <= res_day_in;
      res_month_ff <= res_month_in;
      res_year_ff  <= res_year_in;
      res_diff_ff  <= res_diff_in;
      res_stat_ff  <= res_stat_in;
      if (cmd.save_first) begin
         first_ff <= acc_ff;
      end
      if (cmd.out_load) begin
         out_ff <= {1'b0, res_stat_ff, res_diff_ff, res_year_ff, res_month_ff, res_day_ff};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

// ----- rtl/core/gdad_ctrl.sv -----
// controller: sequences the walks, checks and result handoff
module gdad_ctrl
   import gdad_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.res_sel = RES_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = ST_WALK_YEAR1;
            end
         end
         ST_WALK_YEAR1: begin
            if (stat.year_hit) begin
               state_in = ST_WALK_MONTH1;
            end else begin
               cmd.year_add = 1'b1;
            end
         end
         ST_WALK_MONTH1: begin
            if (stat.month_hit) begin
               state_in = ST_CHECK1;
            end else begin
               cmd.month_add = 1'b1;
            end
         end
         ST_CHECK1: begin
            if (!stat.date_ok) begin
               cmd.res_sel = RES_BAD_FIRST;
               state_in    = ST_FINISH;
            end else begin
               cmd.offset = 1'b1;
               state_in   = (stat.mode == MODE_ADD) ? ST_SPLIT_YEAR : ST_SAVE;
            end
         end
         ST_SAVE: begin
            cmd.save_first = 1'b1;
            cmd.clear      = 1'b1;
            state_in       = ST_WALK_YEAR2;
         end
         ST_WALK_YEAR2: begin
            cmd.sel_second = 1'b1;
            if (stat.year_hit) begin
               state_in = ST_WALK_MONTH2;
            end else begin
               cmd.year_add = 1'b1;
            end
         end
         ST_WALK_MONTH2: begin
            cmd.sel_second = 1'b1;
            if (stat.month_hit) begin
               state_in = ST_CHECK2;
            end else begin
               cmd.month_add = 1'b1;
            end
         end
         ST_CHECK2: begin
            cmd.sel_second = 1'b1;
            if (!stat.date_ok) begin
               cmd.res_sel = RES_BAD_SECOND;
               state_in    = ST_FINISH;
            end else begin
               cmd.offset = 1'b1;
               state_in   = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.res_sel = RES_DIFF;
            state_in    = ST_FINISH;
         end
         ST_SPLIT_YEAR: begin
            if (stat.year_more) begin
               if (stat.year_last) begin
                  cmd.res_sel = RES_OVERFLOW;
                  state_in    = ST_FINISH;
               end else begin
                  cmd.year_sub = 1'b1;
               end
            end else begin
               state_in = ST_SPLIT_MONTH;
            end
         end
         ST_SPLIT_MONTH: begin
            if (stat.month_more) begin
               cmd.month_sub = 1'b1;
            end else begin
               cmd.res_sel = RES_DATE;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/core/gregorian_date_add_and_difference_top.sv -----
// top level of the gregorian date add and difference block
//
//   channel | direction | ports                     | contents
//   req     | in        | req_tvalid/tready/tdata/tuser | two dates, day count; tuser = mode
//   rsp     | out       | rsp_tvalid/tready/tdata   | result date, difference, status
//
// one item at a time; dates become day numbers by stepping a year and month walker,
// one year or one month per cycle through the shared accumulator
// add: walks the years and months of the first date, then splits the sum into result years and months
// difference: walks the years and months of both dates, then takes the absolute difference
// a new item is taken while the previous result waits in the output register
// reset is synchronous and clears the controller and output valid
module gregorian_date_add_and_difference_top
   import gdad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_day, first_month, first_year, second_day, second_month, second_year,
   // day_count, zero fill
   input  logic [71:0] req_tdata,
   // mode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_day, result_month, result_year, day_difference, status, zero fill
   output logic [47:0] rsp_tdata
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   gdad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // walker and result datapath
   gdad_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule
